@@ hw/rtl/assert_macros.svh @@
// Assertion macros for the run embedder RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, sampled on clk, idle while rst_n is low
`define LARE_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication
`define LARE_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication
`define LARE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/lare_pkg.sv @@
// Types, constants and the channel order table for the run embedder
package lare_pkg;

    localparam int NUM_CHAN   = 3;
    localparam int NUM_ORDERS = 6;
    localparam int RUN_MAX    = 3;
    localparam logic [3:0] MAX_BITS    = 4'd9;
    localparam logic [7:0] KEEP_MASK   = 8'hFC;
    localparam logic [2:0] LAST_SHIFT  = 3'd5;

    typedef enum logic [1:0] {
        CFG_SHIFT_FIRST  = 2'd0,
        CFG_SHIFT_SECOND = 2'd1,
        CFG_SHIFT_THIRD  = 2'd2,
        CFG_ORDER_SEARCH = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [8:0] msg_window;
        logic [3:0] bits_left;
    } item_t;

    typedef struct packed {
        logic [7:0] new_red;
        logic [7:0] new_green;
        logic [7:0] new_blue;
        logic [3:0] bits_used;
        logic [2:0] order_code;
    } result_t;

    typedef struct packed {
        logic [2:0] first;
        logic [2:0] second;
        logic [2:0] third;
    } shift_t;

    typedef logic [NUM_CHAN-1:0][7:0] chans_t;
    typedef logic [NUM_CHAN-1:0][1:0] counts_t;

    // Channel visited at place j of order code (RGB, RBG, GRB, GBR, BRG, BGR)
    function automatic logic [1:0] perm_chan(input logic [2:0] code, input logic [1:0] j);
        logic [5:0] row;
        begin
            unique case (code)
                3'd0:    row = {2'd2, 2'd1, 2'd0};
                3'd1:    row = {2'd1, 2'd2, 2'd0};
                3'd2:    row = {2'd2, 2'd0, 2'd1};
                3'd3:    row = {2'd0, 2'd2, 2'd1};
                3'd4:    row = {2'd1, 2'd0, 2'd2};
                3'd5:    row = {2'd0, 2'd1, 2'd2};
                default: row = {2'd2, 2'd1, 2'd0};
            endcase
            unique case (j)
                2'd0:    perm_chan = row[1:0];
                2'd1:    perm_chan = row[3:2];
                default: perm_chan = row[5:4];
            endcase
        end
    endfunction

    // Bit sh of the upper six bits; positions above five read as zero
    function automatic logic chan_bit(input logic [7:0] chan, input logic [2:0] sh);
        begin
            if (sh <= LAST_SHIFT)
                chan_bit = chan[3'd2 + sh];
            else
                chan_bit = 1'b0;
        end
    endfunction

endpackage

@@ hw/rtl/lare_run_count.sv @@
// Run counts of the three channels for one channel order
module lare_run_count (
    input  lare_pkg::chans_t  chans,
    input  logic [8:0]        win,
    input  logic [3:0]        avail,
    input  lare_pkg::shift_t  sh,
    output lare_pkg::counts_t cnt,
    output logic [3:0]        total
);
    import lare_pkg::*;

    logic [3:0] pos;
    logic [8:0] w;
    logic [3:0] left;
    logic [1:0] n;
    logic       go;
    logic [2:0] shk;

    always_comb
    begin
        pos = 4'd0;
        cnt = '0;
        w = '0;
        left = '0;
        n = '0;
        go = 1'b0;
        shk = '0;
        for (int j = 0; j < NUM_CHAN; j++)
        begin
            w    = win >> pos;
            left = (avail > pos) ? (avail - pos) : 4'd0;
            n    = 2'd0;
            go   = 1'b1;
            for (int k = 0; k < RUN_MAX; k++)
            begin
                unique case (k)
                    0:       shk = sh.first;
                    1:       shk = sh.second;
                    default: shk = sh.third;
                endcase
                if (go && (4'(k) < left) && (w[k] == chan_bit(chans[j], shk)))
                    n = n + 2'd1;
                else
                    go = 1'b0;
            end
            cnt[j] = n;
            pos    = pos + {2'b00, n};
        end
        total = pos;
    end

endmodule

@@ hw/rtl/lare_select.sv @@
// Picks the first channel order with the largest total, or order 0 when order_search is low
module lare_select (
    input  logic [lare_pkg::NUM_ORDERS-1:0][3:0]    totals,
    input  lare_pkg::counts_t [lare_pkg::NUM_ORDERS-1:0] cnts,
    input  logic                                    order_search,
    output logic [2:0]                              best_code,
    output logic [3:0]                              best_total,
    output lare_pkg::counts_t                       best_cnt
);
    import lare_pkg::*;

    always_comb
    begin
        best_code  = 3'd0;
        best_total = totals[0];
        best_cnt   = cnts[0];
        // strict compare keeps the lowest code on a tie
        for (int c = 1; c < NUM_ORDERS; c++)
        begin
            if (order_search && (totals[c] > best_total))
            begin
                best_code  = 3'(c);
                best_total = totals[c];
                best_cnt   = cnts[c];
            end
        end
    end

endmodule

@@ hw/rtl/lookahead_lsb_run_embed.sv @@
// A taken pixel passes through the input register and then the result register,
// which drives the result strobe and the result.
// Throughput: one pixel per cycle; busy stays low, so start may be held high.
// One input register and one result register; the order search sits between them.
// Reset (rst_n low, asynchronous) drops both valid flags and restores the shift
// registers to 0, 1, 2 and fixed RGB order; the receiver cannot stall results.
module lookahead_lsb_run_embed (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  lare_pkg::item_t   item,
    output logic              result_valid,
    output lare_pkg::result_t result,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [2:0]        cfg_data
);
    import lare_pkg::*;

    `include "assert_macros.svh"

    shift_t  shift_reg, shift_next;
    logic    search_reg, search_next;
    logic    in_vld_reg;
    item_t   item_reg;
    logic    res_vld_reg;
    result_t res_reg, res_next;

    chans_t                           chans;
    logic [3:0]                       avail;
    chans_t  [NUM_ORDERS-1:0]         perm_chans;
    counts_t [NUM_ORDERS-1:0]         cnts;
    logic    [NUM_ORDERS-1:0][3:0]    totals;
    logic [2:0]                       best_code;
    logic [3:0]                       best_total;
    counts_t                          best_cnt;
    chans_t                           new_chans;
    logic [3:0]                       used_chk;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    // configuration
    always_comb
    begin
        shift_next  = shift_reg;
        search_next = search_reg;
        if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_SHIFT_FIRST:  shift_next.first  = cfg_data;
                CFG_SHIFT_SECOND: shift_next.second = cfg_data;
                CFG_SHIFT_THIRD:  shift_next.third  = cfg_data;
                CFG_ORDER_SEARCH: search_next       = cfg_data[0];
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg   <= '{first: 3'd0, second: 3'd1, third: 3'd2};
            search_reg  <= 1'b0;
            in_vld_reg  <= 1'b0;
            res_vld_reg <= 1'b0;
        end
        else
        begin
            shift_reg   <= shift_next;
            search_reg  <= search_next;
            in_vld_reg  <= start && !busy;
            res_vld_reg <= in_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
            item_reg <= item;
        if (in_vld_reg)
            res_reg <= res_next;
    end

    // evaluation of all six orders
    assign chans = {item_reg.blue, item_reg.green, item_reg.red};
    assign avail = (item_reg.bits_left > MAX_BITS) ? MAX_BITS : item_reg.bits_left;

    always_comb
    begin
        for (int c = 0; c < NUM_ORDERS; c++)
            for (int j = 0; j < NUM_CHAN; j++)
                perm_chans[c][j] = chans[perm_chan(3'(c), 2'(j))];
    end

    for (genvar g = 0; g < NUM_ORDERS; g++)
    begin : g_order
        lare_run_count u_run (
            .chans (perm_chans[g]),
            .win   (item_reg.msg_window),
            .avail (avail),
            .sh    (shift_reg),
            .cnt   (cnts[g]),
            .total (totals[g])
        );
    end

    lare_select u_select (
        .totals       (totals),
        .cnts         (cnts),
        .order_search (search_reg),
        .best_code    (best_code),
        .best_total   (best_total),
        .best_cnt     (best_cnt)
    );

    always_comb
    begin
        new_chans = chans;
        for (int j = 0; j < NUM_CHAN; j++)
            new_chans[perm_chan(best_code, 2'(j))] =
                (chans[perm_chan(best_code, 2'(j))] & KEEP_MASK) | {6'd0, best_cnt[j]};
        res_next.new_red    = new_chans[0];
        res_next.new_green  = new_chans[1];
        res_next.new_blue   = new_chans[2];
        res_next.bits_used  = best_total;
        res_next.order_code = best_code;
    end

    assign result_valid = res_vld_reg;
    assign result       = res_reg;

    assign used_chk = {2'b00, res_reg.new_red[1:0]} + {2'b00, res_reg.new_green[1:0]}
                    + {2'b00, res_reg.new_blue[1:0]};

    `LARE_ASSERT_NEXT(a_result_follows, in_vld_reg, res_vld_reg, "accepted pixel gave no result")
    `LARE_ASSERT_IMPL(a_used_sum, res_vld_reg, used_chk == res_reg.bits_used, "bits_used mismatch")
    `LARE_ASSERT_IMPL(a_code_range, res_vld_reg, res_reg.order_code < 3'd6, "order code out of range")
    `LARE_ASSERT_IMPL(a_fixed_order, res_vld_reg && !search_reg, res_reg.order_code == 3'd0,
                      "order changed in fixed mode")
    `LARE_ASSERT(a_used_max, !res_vld_reg || (res_reg.bits_used <= MAX_BITS), "bits_used above nine")

endmodule
